// ===== rtl/core/slie_pkg.sv =====
// ----------------------------------------------------------------------------
// slie_pkg
// Shared types and constants for the sorted list insert engine.
// ----------------------------------------------------------------------------
package slie_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int TYPE_W   = 3;
  localparam int RIDX_W   = 6;
  localparam int RCNT_W   = 7;
  localparam int ST_W     = 3;
  localparam int WIDE_W   = (CNT_W > RCNT_W) ? CNT_W : RCNT_W;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ADD   = 3'd0,
    REQ_GET   = 3'd1,
    REQ_TAKE  = 3'd2,
    REQ_FIND  = 3'd3,
    REQ_POP   = 3'd4,
    REQ_CLEAR = 3'd5
  } req_code_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_COMMIT
  } fsm_state_t;

  typedef struct packed {
    logic [TYPE_W-1:0]        req_type;
    logic signed [DATA_W-1:0] req_value;
    logic [RIDX_W-1:0]        req_index;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic [RIDX_W-1:0]        out_index;
    logic [RCNT_W-1:0]        entry_count;
    logic [ST_W-1:0]          status;
  } out_rsp_t;

  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic [IDX_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

  typedef struct packed {
    logic le;
    logic lt;
    logic ins_here;
    logic hit;
  } cell_flag_t;

endpackage

// ===== rtl/core/slie_cell.sv =====
// ----------------------------------------------------------------------------
// slie_cell
// One list slot: compares against the probe value and shifts left or right.
// ----------------------------------------------------------------------------
module slie_cell (
  input  logic                           clk,
  input  logic [slie_pkg::IDX_W-1:0]     cell_pos,
  input  logic [slie_pkg::CNT_W-1:0]     count,
  input  logic signed [slie_pkg::DATA_W-1:0] cmp_value,
  input  slie_pkg::cell_ctrl_t           ctrl,
  input  logic [slie_pkg::DATA_W-1:0]    left_value,
  input  logic [slie_pkg::DATA_W-1:0]    right_value,
  input  logic                           prev_le,
  input  logic                           prev_lt,
  output logic [slie_pkg::DATA_W-1:0]    value,
  output slie_pkg::cell_flag_t           flags
);
  import slie_pkg::*;

  logic signed [DATA_W-1:0] value_r;
  logic                     occupied;
  logic                     eq;

  assign value = value_r;

  always_comb begin
    occupied       = CNT_W'(cell_pos) < count;
    eq             = occupied && (value_r == cmp_value);
    flags.le       = occupied && (value_r <= cmp_value);
    flags.lt       = occupied && (value_r < cmp_value);
    flags.ins_here = prev_le && !flags.le;
    flags.hit      = prev_lt && eq;
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (cell_pos == ctrl.pos) begin
        value_r <= ctrl.value;
      end else if (cell_pos > ctrl.pos) begin
        value_r <= left_value;
      end
    end else if (ctrl.del && (cell_pos >= ctrl.pos)) begin
      value_r <= right_value;
    end
  end

endmodule

// ===== rtl/core/slie_chain.sv =====
// ----------------------------------------------------------------------------
// slie_chain
// Row of list cells with insert-point and first-match encoders.
// ----------------------------------------------------------------------------
module slie_chain (
  input  logic                                              clk,
  input  logic [slie_pkg::CNT_W-1:0]                        count,
  input  logic signed [slie_pkg::DATA_W-1:0]                cmp_value,
  input  slie_pkg::cell_ctrl_t                              ctrl,
  output logic [slie_pkg::CAPACITY-1:0][slie_pkg::DATA_W-1:0] cell_values,
  output logic [slie_pkg::IDX_W-1:0]                        ins_pos,
  output logic [slie_pkg::IDX_W-1:0]                        hit_pos,
  output logic                                              hit_any
);
  import slie_pkg::*;

  cell_flag_t              flags   [CAPACITY];
  logic [CAPACITY-1:0]     prev_le;
  logic [CAPACITY-1:0]     prev_lt;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_le[i] = 1'b1;
      assign prev_lt[i] = 1'b1;
    end else begin : g_body
      assign prev_le[i] = flags[i-1].le;
      assign prev_lt[i] = flags[i-1].lt;
    end

    slie_cell u_cell (
      .clk         (clk),
      .cell_pos    (IDX_W'(i)),
      .count       (count),
      .cmp_value   (cmp_value),
      .ctrl        (ctrl),
      .left_value  (cell_values[(i == 0) ? 0 : i - 1]),
      .right_value (cell_values[(i == CAPACITY - 1) ? i : i + 1]),
      .prev_le     (prev_le[i]),
      .prev_lt     (prev_lt[i]),
      .value       (cell_values[i]),
      .flags       (flags[i])
    );
  end

  // sorted contents: at most one boundary cell of each kind
  always_comb begin
    ins_pos = '0;
    hit_pos = '0;
    hit_any = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (flags[i].ins_here) begin
        ins_pos = ins_pos | IDX_W'(i);
      end
      if (flags[i].hit) begin
        hit_pos = hit_pos | IDX_W'(i);
        hit_any = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/sorted_list_insert_engine_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_engine_unit
// Bounded ascending list of signed 32-bit values with add, get, take, find,
// pop-largest and clear requests; one response per request.
// ----------------------------------------------------------------------------
// After acceptance each request passes through an evaluate state and a commit
// state, and in_stall is high in both: in the evaluate state every cell of the
// row compares its entry with the request value and the boundary encoders and
// read mux settle, and in the commit state the row shifts its entries and the
// response is loaded into the output register. A waiting response does not
// block the next request; only the commit state waits for the output register
// to be free. Adds to a full list and accesses to an empty one are flagged in
// status rather than changing the list.
module sorted_list_insert_engine_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  slie_pkg::in_req_t in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output slie_pkg::out_rsp_t out_rsp
);
  import slie_pkg::*;

  fsm_state_t  state_r, state_nxt;
  in_req_t     req_r;
  logic [CNT_W-1:0] count_r;
  out_rsp_t    rsp_r, rsp_eval;
  logic [CNT_W-1:0] cnt_pend_r, cnt_eval;
  cell_ctrl_t  ctrl_pend_r, ctrl_eval, ctrl_cells;
  out_rsp_t    out_rsp_r;
  logic        out_valid_r;
  logic        fire;

  logic [CAPACITY-1:0][DATA_W-1:0] cell_values;
  logic [IDX_W-1:0] ins_pos, hit_pos, rd_sel;
  logic             hit_any;
  logic [WIDE_W-1:0] idx_w, cnt_w;
  logic             is_empty, is_full;

  slie_chain u_chain (
    .clk         (clk),
    .count       (count_r),
    .cmp_value   (req_r.req_value),
    .ctrl        (ctrl_cells),
    .cell_values (cell_values),
    .ins_pos     (ins_pos),
    .hit_pos     (hit_pos),
    .hit_any     (hit_any)
  );

  always_comb begin
    ctrl_cells     = ctrl_pend_r;
    ctrl_cells.ins = ctrl_pend_r.ins && fire;
    ctrl_cells.del = ctrl_pend_r.del && fire;
  end

  always_comb begin
    idx_w    = WIDE_W'(req_r.req_index);
    cnt_w    = WIDE_W'(count_r);
    is_empty = (count_r == '0);
    is_full  = (cnt_w == WIDE_W'(CAPACITY));
    rd_sel   = (req_r.req_type == REQ_POP) ? IDX_W'(count_r - 1'b1) : idx_w[IDX_W-1:0];

    rsp_eval        = '0;
    rsp_eval.status = ST_OK;
    cnt_eval        = count_r;
    ctrl_eval       = '0;
    ctrl_eval.value = req_r.req_value;
    ctrl_eval.pos   = ins_pos;

    case (req_r.req_type)
      REQ_ADD: begin
        if (is_full) begin
          rsp_eval.status = ST_FULL;
        end else begin
          ctrl_eval.ins      = 1'b1;
          rsp_eval.out_index = RIDX_W'(ins_pos);
          cnt_eval           = CNT_W'(count_r + 1'b1);
        end
      end
      REQ_GET, REQ_TAKE: begin
        if (is_empty) begin
          rsp_eval.status = ST_EMPTY;
        end else if (idx_w >= cnt_w) begin
          rsp_eval.status = ST_BADIDX;
        end else begin
          rsp_eval.out_value = cell_values[rd_sel];
          if (req_r.req_type == REQ_TAKE) begin
            ctrl_eval.del = 1'b1;
            ctrl_eval.pos = rd_sel;
            cnt_eval      = CNT_W'(count_r - 1'b1);
          end
        end
      end
      REQ_FIND: begin
        if (hit_any) begin
          rsp_eval.out_index = RIDX_W'(hit_pos);
        end else begin
          rsp_eval.status = ST_NOTFOUND;
        end
      end
      REQ_POP: begin
        if (is_empty) begin
          rsp_eval.status = ST_EMPTY;
        end else begin
          rsp_eval.out_value = cell_values[rd_sel];
          cnt_eval           = CNT_W'(count_r - 1'b1);
        end
      end
      REQ_CLEAR: begin
        cnt_eval = '0;
      end
      default: begin
      end
    endcase
    rsp_eval.entry_count = RCNT_W'(cnt_eval);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fire      = 1'b0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_valid_r || !out_stall) begin
          fire      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r     <= cnt_pend_r;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r <= in_req;
    end
    if (state_r == S_EVAL) begin
      rsp_r       <= rsp_eval;
      cnt_pend_r  <= cnt_eval;
      ctrl_pend_r <= ctrl_eval;
    end
    if (fire) begin
      out_rsp_r <= rsp_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ===== rtl/core/slie_checker.sv =====
// ----------------------------------------------------------------------------
// slie_checker
// Port-level checks for the sorted list insert engine, bound to the top level.
// ----------------------------------------------------------------------------
module slie_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input slie_pkg::in_req_t  in_req,
  input logic               out_valid,
  input logic               out_stall,
  input slie_pkg::out_rsp_t out_rsp
);
  import slie_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("response changed while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in progress");

  a_full_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status == ST_FULL) |->
      (out_rsp.out_value == '0) && (out_rsp.out_index == '0))
    else $error("full response carries data");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status == ST_EMPTY) |-> (out_rsp.entry_count == '0))
    else $error("empty response with non-zero count");

  a_notfound_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status == ST_NOTFOUND) |->
      (out_rsp.out_index == '0) && (out_rsp.out_value == '0))
    else $error("not-found response carries data");

endmodule

bind sorted_list_insert_engine_unit slie_checker u_slie_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_list_insert_engine_unit. A directed table
// covers the empty list, extreme values, duplicates, bad indexes, unused codes
// and clear. Random streams then fill the list past full and drain it past
// empty, with mixed traffic around them, under four idle and stall profiles.
// Responses are checked against a behavioural model or a typed table row.
// ----------------------------------------------------------------------------
module tb;
  import slie_pkg::*;

  localparam logic [TYPE_W-1:0]        REQ_RSV6  = 3'd6;
  localparam logic [TYPE_W-1:0]        REQ_RSV7  = 3'd7;
  localparam logic signed [DATA_W-1:0] VAL_MIN   = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX   = 32'sh7fff_ffff;
  localparam int                       N_DIR     = 25;
  localparam int                       MAX_SHOWN = 10;

  typedef struct packed {
    logic [TYPE_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    logic [RIDX_W-1:0]        index;
    logic                     typed;
    out_rsp_t                 rsp;
  } dir_row_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_rsp;

  logic signed [DATA_W-1:0] list_vals [CAPACITY];
  int                       list_cnt = 0;
  out_rsp_t                 awaited_rsps [$];
  int                       tx_idle_pct  = 0;
  int                       rx_stall_pct = 0;
  int                       err_cnt = 0;
  int                       n_req   = 0;
  int                       n_rsp   = 0;
  int                       status_seen [8];
  dir_row_t                 dir_tab [N_DIR];

  sorted_list_insert_engine_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_rsp_t sorted_list_apply(input in_req_t r);
    out_rsp_t o;
    int       pos;
    int       i;
    o = '0;
    case (r.req_type)
      REQ_ADD: begin
        if (list_cnt >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < list_cnt && list_vals[pos] <= r.req_value) pos++;
          for (i = list_cnt; i > pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = r.req_value;
          list_cnt++;
          o.out_index = RIDX_W'(pos);
        end
      end
      REQ_GET, REQ_TAKE: begin
        if (list_cnt == 0) begin
          o.status = ST_EMPTY;
        end else if (int'(r.req_index) >= list_cnt) begin
          o.status = ST_BADIDX;
        end else begin
          o.out_value = list_vals[r.req_index];
          if (r.req_type == REQ_TAKE) begin
            for (i = int'(r.req_index); i + 1 < list_cnt; i++)
              list_vals[i] = list_vals[i+1];
            list_cnt--;
          end
        end
      end
      REQ_FIND: begin
        o.status = ST_NOTFOUND;
        for (i = 0; i < list_cnt; i++) begin
          if (o.status == ST_NOTFOUND && list_vals[i] == r.req_value) begin
            o.out_index = RIDX_W'(i);
            o.status    = ST_OK;
          end
        end
      end
      REQ_POP: begin
        if (list_cnt == 0) begin
          o.status = ST_EMPTY;
        end else begin
          list_cnt--;
          o.out_value = list_vals[list_cnt];
        end
      end
      REQ_CLEAR: begin
        list_cnt = 0;
      end
      default: begin
      end
    endcase
    o.entry_count = RCNT_W'(list_cnt);
    return o;
  endfunction

  // small values give duplicates, extremes hit the ordering corners
  function automatic logic signed [DATA_W-1:0] pick_value();
    int                       sel;
    logic signed [DATA_W-1:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      v = $signed($urandom_range(0, 8)) - 4;
    end else if (sel < 35) begin
      case ($urandom_range(0, 3))
        0:       v = VAL_MIN;
        1:       v = VAL_MAX;
        2:       v = 0;
        default: v = -32'sd1;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  function automatic in_req_t random_req(input logic [TYPE_W-1:0] kind);
    in_req_t r;
    r.req_type  = kind;
    r.req_value = pick_value();
    r.req_index = RIDX_W'($urandom_range(0, 63));
    if (kind == REQ_FIND && list_cnt > 0 && $urandom_range(0, 99) < 60)
      r.req_value = list_vals[IDX_W'($urandom_range(0, list_cnt - 1))];
    if ((kind == REQ_GET || kind == REQ_TAKE) && list_cnt > 0 &&
        $urandom_range(0, 99) < 80)
      r.req_index = RIDX_W'($urandom_range(0, list_cnt - 1));
    return r;
  endfunction

  function automatic logic [TYPE_W-1:0] mixed_kind();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35)      return REQ_ADD;
    else if (sel < 50) return REQ_GET;
    else if (sel < 63) return REQ_TAKE;
    else if (sel < 78) return REQ_FIND;
    else if (sel < 93) return REQ_POP;
    else if (sel < 96) return REQ_CLEAR;
    else if (sel < 98) return REQ_RSV6;
    else               return REQ_RSV7;
  endfunction

  task automatic send_req(input in_req_t r, input logic typed, input out_rsp_t typed_rsp);
    out_rsp_t pred;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    pred = sorted_list_apply(r);
    awaited_rsps.push_back(typed ? typed_rsp : pred);
    n_req++;
  endtask

  task automatic drain_rsps();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (awaited_rsps.size() == 0);
    @(posedge clk);
  endtask

  task automatic check_rsp(input out_rsp_t got);
    out_rsp_t want;
    n_rsp++;
    if (awaited_rsps.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MAX_SHOWN)
        $display("unexpected response: value %0d idx %0d cnt %0d st %0d",
                 got.out_value, got.out_index, got.entry_count, got.status);
    end else begin
      want = awaited_rsps.pop_front();
      status_seen[want.status]++;
      if (got.out_value !== want.out_value || got.out_index !== want.out_index ||
          got.entry_count !== want.entry_count || got.status !== want.status) begin
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
          $display("mismatch: exp value %0d idx %0d cnt %0d st %0d, got %0d %0d %0d %0d",
                   want.out_value, want.out_index, want.entry_count, want.status,
                   got.out_value, got.out_index, got.entry_count, got.status);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_rsp(out_rsp);
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  initial begin
    in_req_t req;
    int      d;
    int      p;
    dir_tab = '{
      '{REQ_GET,   32'sd0,    6'd0,  1'b1, '{32'sd0, 6'd0, 7'd0, ST_EMPTY}},
      '{REQ_TAKE,  32'sd0,    6'd5,  1'b1, '{32'sd0, 6'd0, 7'd0, ST_EMPTY}},
      '{REQ_POP,   32'sd0,    6'd0,  1'b1, '{32'sd0, 6'd0, 7'd0, ST_EMPTY}},
      '{REQ_FIND,  32'sd0,    6'd0,  1'b1, '{32'sd0, 6'd0, 7'd0, ST_NOTFOUND}},
      '{REQ_ADD,   VAL_MAX,   6'd0,  1'b1, '{32'sd0, 6'd0, 7'd1, ST_OK}},
      '{REQ_ADD,   VAL_MIN,   6'd63, 1'b1, '{32'sd0, 6'd0, 7'd2, ST_OK}},
      '{REQ_ADD,   32'sd0,    6'd0,  1'b1, '{32'sd0, 6'd1, 7'd3, ST_OK}},
      '{REQ_ADD,   -32'sd1,   6'd0,  1'b1, '{32'sd0, 6'd1, 7'd4, ST_OK}},
      '{REQ_ADD,   32'sd0,    6'd0,  1'b1, '{32'sd0, 6'd3, 7'd5, ST_OK}},
      '{REQ_GET,   32'sd0,    6'd4,  1'b1, '{VAL_MAX, 6'd0, 7'd5, ST_OK}},
      '{REQ_GET,   32'sd0,    6'd63, 1'b1, '{32'sd0, 6'd0, 7'd5, ST_BADIDX}},
      '{REQ_GET,   32'sd0,    6'd5,  1'b1, '{32'sd0, 6'd0, 7'd5, ST_BADIDX}},
      '{REQ_FIND,  32'sd0,    6'd0,  1'b0, '0},
      '{REQ_FIND,  32'sd12345, 6'd0, 1'b1, '{32'sd0, 6'd0, 7'd5, ST_NOTFOUND}},
      '{REQ_FIND,  VAL_MIN,   6'd0,  1'b0, '0},
      '{REQ_TAKE,  32'sd0,    6'd0,  1'b0, '0},
      '{REQ_RSV6,  VAL_MAX,   6'd63, 1'b1, '{32'sd0, 6'd0, 7'd4, ST_OK}},
      '{REQ_RSV7,  -32'sd1,   6'd42, 1'b1, '{32'sd0, 6'd0, 7'd4, ST_OK}},
      '{REQ_POP,   32'sd0,    6'd0,  1'b0, '0},
      '{REQ_ADD,   VAL_MAX,   6'd0,  1'b0, '0},
      '{REQ_TAKE,  32'sd0,    6'd63, 1'b1, '{32'sd0, 6'd0, 7'd4, ST_BADIDX}},
      '{REQ_CLEAR, 32'sd0,    6'd0,  1'b1, '{32'sd0, 6'd0, 7'd0, ST_OK}},
      '{REQ_GET,   32'sd0,    6'd0,  1'b1, '{32'sd0, 6'd0, 7'd0, ST_EMPTY}},
      '{REQ_FIND,  -32'sd1,   6'd0,  1'b1, '{32'sd0, 6'd0, 7'd0, ST_NOTFOUND}},
      '{REQ_ADD,   -32'sd1,   6'd0,  1'b1, '{32'sd0, 6'd0, 7'd1, ST_OK}}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (d = 0; d < N_DIR; d++) begin
      req.req_type  = dir_tab[d].kind;
      req.req_value = dir_tab[d].value;
      req.req_index = dir_tab[d].index;
      send_req(req, dir_tab[d].typed, dir_tab[d].rsp);
    end
    drain_rsps();

    // even phases fill past full, odd phases drain past empty
    for (p = 0; p < 4; p++) begin
      case (p)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 47; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 47; end
        default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
      endcase
      repeat (20) send_req(random_req(mixed_kind()), 1'b0, '0);
      if (p % 2 == 0) begin
        while (list_cnt < CAPACITY) send_req(random_req(REQ_ADD), 1'b0, '0);
        repeat (2) send_req(random_req(REQ_ADD), 1'b0, '0);
      end else begin
        while (list_cnt > 0)
          send_req(random_req($urandom_range(0, 1) ? REQ_TAKE : REQ_POP), 1'b0, '0);
        send_req(random_req(REQ_POP), 1'b0, '0);
        send_req(random_req(REQ_TAKE), 1'b0, '0);
      end
      repeat (20) send_req(random_req(mixed_kind()), 1'b0, '0);
      drain_rsps();
    end

    repeat (20) @(posedge clk);
    $display("tb: %0d requests, %0d responses under four idle/stall profiles",
             n_req, n_rsp);
    $display("tb: full %0d, empty %0d, bad index %0d, not found %0d, errors %0d",
             status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_BADIDX],
             status_seen[ST_NOTFOUND], err_cnt);
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: timeout");
    $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/slie_pkg.sv
rtl/core/slie_cell.sv
rtl/core/slie_chain.sv
rtl/core/sorted_list_insert_engine_unit.sv
rtl/core/slie_checker.sv
test/tb.sv
